FILE: rtl/core/ebis_pkg.sv
`timescale 1ns / 1ps

package ebis_pkg;

   // Phase tick counter width
   localparam int TICK_COUNT_WIDTH = 32;
   localparam int TICK_CMP_WIDTH   = (TICK_COUNT_WIDTH > 32) ? TICK_COUNT_WIDTH : 32;

   localparam int REQ_TDATA_WIDTH = 96;
   localparam int REQ_ITEM_WIDTH  = 91;
   localparam int REQ_TUSER_WIDTH = 3;
   localparam int RSP_TDATA_WIDTH = 24;
   localparam int RSP_ITEM_WIDTH  = 17;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Fixed thresholds, tenths of a degree or tenths of a percent
   localparam logic [31:0]        WARMUP_DEFAULT_TICKS = 32'd250;
   localparam logic signed [13:0] ENGINE_FAN_MARGIN    = 14'sd100;
   localparam logic signed [12:0] DYNO_FAN_TEMP        = 13'sd800;
   localparam logic signed [12:0] RESISTOR_FAN_TEMP    = 13'sd1000;
   localparam logic [9:0]         LOW_OIL_LVL          = 10'd100;
   localparam logic [9:0]         LOW_FUEL_LVL         = 10'd50;

   typedef logic [TICK_COUNT_WIDTH-1:0] tick_count_type;
   typedef logic [TICK_CMP_WIDTH-1:0]   tick_cmp_type;

   typedef enum logic [2:0] {
      KIND_TICK      = 3'd0,
      KIND_START     = 3'd1,
      KIND_STOP      = 3'd2,
      KIND_ESTOP     = 3'd3,
      KIND_NEXT      = 3'd4,
      KIND_RESET_EMG = 3'd5,
      KIND_SET_MODE  = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_COLD     = 3'd1,
      PH_WARMUP   = 3'd2,
      PH_HOT_NL   = 3'd3,
      PH_HOT_LOAD = 3'd4,
      PH_STOPPED  = 3'd5,
      PH_EMERG    = 3'd6
   } phase_type;

   localparam logic [1:0] MODE_COLD     = 2'd0;
   localparam logic [1:0] MODE_HOT_NL   = 2'd1;
   localparam logic [1:0] MODE_HOT_LOAD = 2'd2;

   localparam logic [2:0] CSR_MAX_ENG_TEMP    = 3'd0;
   localparam logic [2:0] CSR_MIN_OIL_PRESS   = 3'd1;
   localparam logic [2:0] CSR_MAX_OIL_PRESS   = 3'd2;
   localparam logic [2:0] CSR_MAX_ENG_SPEED   = 3'd3;
   localparam logic [2:0] CSR_MAX_DYNO_TEMP   = 3'd4;
   localparam logic [2:0] CSR_MAX_RES_TEMP    = 3'd5;
   localparam logic [2:0] CSR_PHASE_TICKS     = 3'd6;
   localparam logic [2:0] CSR_WARMUP_TICKS    = 3'd7;

   // Request payload, first member in the highest bits
   typedef struct packed {
      logic [9:0]         fuel_lvl;
      logic [9:0]         oil_lvl;
      logic signed [12:0] res_temp;
      logic signed [12:0] dyno_temp;
      logic [13:0]        eng_speed;
      logic [15:0]        oil_press;
      logic signed [12:0] eng_temp;
      logic [1:0]         mode;
   } req_item_type;

   // Result payload, first member in the highest bits
   typedef struct packed {
      logic [1:0] warning_flags;
      logic [4:0] error_flags;
      logic       resistor_fan_on;
      logic       dyno_fan_on;
      logic       engine_fan_on;
      logic       eng_running;
      logic       dyno_brake;
      logic [1:0] current_mode;
      logic [2:0] phase;
   } rsp_item_type;

   // Saturate a mode code to the three defined modes
   function automatic logic [1:0] sat_mode(input logic [1:0] m);
      sat_mode = (m == 2'd3) ? MODE_HOT_LOAD : m;
   endfunction

   function automatic logic is_active(input phase_type ph);
      is_active = (ph == PH_COLD) || (ph == PH_WARMUP) ||
                  (ph == PH_HOT_NL) || (ph == PH_HOT_LOAD);
   endfunction

endpackage

FILE: rtl/core/engine_breakin_sequencer_top.sv
`timescale 1ns / 1ps

// Engine break-in sequencer.
// The req_ channel carries one transaction per command or sensor tick; the
// kind travels on req_tuser and the mode plus sensor sample on req_tdata.
// Every request transaction yields exactly one rsp_ transaction with the
// phase, held mode, brake, running flag, fan flags and, for ticks in an
// active phase, the limit error and low-level warning flags.
// The csr_ channel writes the eight limit and duration registers; it is
// always ready and must only be used while no request is in flight.
// A request passes one input register, one pass of compare and update logic
// and one result register before its result is valid.
// Throughput is one transaction per cycle while the result side is not
// stalled, with the state update done between the two registers.
// When rsp_tready is low the result register holds and the input register
// fills; req_tready drops only when both are full.
// Synchronous reset empties both registers, returns to idle in cold mode
// with brake released, fans off, tick count clear and default limits.
module engine_breakin_sequencer_top import ebis_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // mode[1:0], eng_temp[14:2], oil_press[30:15], eng_speed[44:31],
   // dyno_temp[57:45], res_temp[70:58], oil_lvl[80:71],
   // fuel_lvl[90:81], zero fill [95:91]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // kind[2:0]
   input  logic [REQ_TUSER_WIDTH-1:0] req_tuser,
   // Result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // phase[2:0], current_mode[4:3], dyno_brake[5], eng_running[6],
   // engine_fan_on[7], dyno_fan_on[8], resistor_fan_on[9],
   // error_flags[14:10], warning_flags[16:15], zero fill [23:17]
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // Configuration write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Configuration registers
   logic signed [12:0] max_et_ff;
   logic [15:0]        min_op_ff;
   logic [15:0]        max_op_ff;
   logic [13:0]        max_rpm_ff;
   logic signed [12:0] max_dt_ff;
   logic signed [12:0] max_rt_ff;
   logic [31:0]        phase_dur_ff;
   logic [31:0]        warm_dur_ff;

   // Input stage
   logic               in_valid_ff;
   req_item_type       item_ff;
   kind_type           kind_ff;

   // Result stage
   logic               out_valid_ff;
   rsp_item_type       out_ff;
   rsp_item_type       out_in;

   // Sequencer state
   phase_type          phase_ff, phase_in;
   logic [1:0]         mode_ff, mode_in;
   logic               brake_ff, brake_in;
   logic               pend_ff, pend_in;
   tick_count_type     ticks_ff, ticks_in;
   logic [2:0]         fan_ff, fan_in;

   logic               out_free;
   logic               move;
   logic               tick_active;
   logic [4:0]         err_now;
   logic [1:0]         warn_now;
   logic [2:0]         fan_now;
   logic [31:0]        warm_len;
   phase_type          hot_phase;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign move       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_WIDTH'(out_ff);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_et_ff    <= 13'sd1100;
         min_op_ff    <= 16'd100;
         max_op_ff    <= 16'd6000;
         max_rpm_ff   <= 14'd4000;
         max_dt_ff    <= 13'sd1200;
         max_rt_ff    <= 13'sd2000;
         phase_dur_ff <= 32'd3000;
         warm_dur_ff  <= 32'd250;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ENG_TEMP:  max_et_ff    <= csr_wdata[12:0];
            CSR_MIN_OIL_PRESS: min_op_ff    <= csr_wdata[15:0];
            CSR_MAX_OIL_PRESS: max_op_ff    <= csr_wdata[15:0];
            CSR_MAX_ENG_SPEED: max_rpm_ff   <= csr_wdata[13:0];
            CSR_MAX_DYNO_TEMP: max_dt_ff    <= csr_wdata[12:0];
            CSR_MAX_RES_TEMP:  max_rt_ff    <= csr_wdata[12:0];
            CSR_PHASE_TICKS:   phase_dur_ff <= csr_wdata;
            CSR_WARMUP_TICKS:  warm_dur_ff  <= csr_wdata;
            default:           max_et_ff    <= max_et_ff;
         endcase
      end
   end

   // Capture request transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item_type'(req_tdata[REQ_ITEM_WIDTH-1:0]);
         kind_ff <= kind_type'(req_tuser);
      end
   end

   // Limit, fan and warning checks on the held sample
   always_comb begin
      err_now[0] = item_ff.eng_temp > max_et_ff;
      err_now[1] = (item_ff.oil_press < min_op_ff) ||
                   (item_ff.oil_press > max_op_ff);
      err_now[2] = item_ff.eng_speed > max_rpm_ff;
      err_now[3] = item_ff.dyno_temp > max_dt_ff;
      err_now[4] = item_ff.res_temp > max_rt_ff;

      fan_now[0] = $signed({item_ff.eng_temp[12], item_ff.eng_temp}) >
                   ($signed({max_et_ff[12], max_et_ff}) - ENGINE_FAN_MARGIN);
      fan_now[1] = item_ff.dyno_temp > DYNO_FAN_TEMP;
      fan_now[2] = item_ff.res_temp > RESISTOR_FAN_TEMP;

      warn_now[0] = item_ff.oil_lvl < LOW_OIL_LVL;
      warn_now[1] = item_ff.fuel_lvl < LOW_FUEL_LVL;
   end

   assign tick_active = (kind_ff == KIND_TICK) && is_active(phase_ff);
   assign warm_len    = (warm_dur_ff == 32'd0) ? WARMUP_DEFAULT_TICKS : warm_dur_ff;
   assign hot_phase   = (mode_ff == MODE_HOT_NL) ? PH_HOT_NL : PH_HOT_LOAD;

   // Next state
   always_comb begin
      phase_type      ph_v;
      tick_count_type ticks_v;

      phase_in = phase_ff;
      mode_in  = mode_ff;
      brake_in = brake_ff;
      pend_in  = pend_ff;
      ticks_in = ticks_ff;
      fan_in   = fan_ff;
      ph_v     = phase_ff;
      ticks_v  = ticks_ff;

      if (move) begin
         case (kind_ff)
            KIND_TICK: begin
               if (tick_active) begin
                  // Carry out a pending next-stage request
                  if (pend_ff) begin
                     pend_in = 1'b0;
                     if (phase_ff == PH_WARMUP) begin
                        ph_v    = hot_phase;
                        ticks_v = '0;
                     end else begin
                        ph_v = PH_STOPPED;
                     end
                  end
                  fan_in = fan_now;
                  // Advance the phase timer
                  if (is_active(ph_v)) begin
                     if (ticks_v != '1) begin
                        ticks_v = ticks_v + 1'b1;
                     end
                     if (ph_v == PH_WARMUP) begin
                        if (tick_cmp_type'(ticks_v) >= tick_cmp_type'(warm_len)) begin
                           ph_v    = hot_phase;
                           ticks_v = '0;
                        end
                     end else if (tick_cmp_type'(ticks_v) >=
                                  tick_cmp_type'(phase_dur_ff)) begin
                        ph_v = PH_STOPPED;
                     end
                  end
                  // Any limit error wins
                  if (err_now != 5'd0) begin
                     ph_v = PH_EMERG;
                  end
                  phase_in = ph_v;
                  ticks_in = ticks_v;
               end
            end
            KIND_START: begin
               mode_in  = sat_mode(item_ff.mode);
               pend_in  = 1'b0;
               ticks_in = '0;
               if (sat_mode(item_ff.mode) == MODE_COLD) begin
                  phase_in = PH_COLD;
                  brake_in = 1'b0;
               end else begin
                  phase_in = PH_WARMUP;
                  brake_in = (sat_mode(item_ff.mode) == MODE_HOT_LOAD);
               end
            end
            KIND_STOP:  phase_in = PH_IDLE;
            KIND_ESTOP: phase_in = PH_EMERG;
            KIND_NEXT:  pend_in  = 1'b1;
            KIND_RESET_EMG: begin
               if (phase_ff == PH_EMERG) begin
                  phase_in = PH_IDLE;
                  pend_in  = 1'b0;
               end
            end
            KIND_SET_MODE: mode_in = sat_mode(item_ff.mode);
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Result fields from the updated state
   always_comb begin
      out_in.phase           = phase_in;
      out_in.current_mode    = mode_in;
      out_in.dyno_brake      = brake_in;
      out_in.eng_running     = (phase_in == PH_WARMUP) || (phase_in == PH_HOT_NL) ||
                               (phase_in == PH_HOT_LOAD);
      out_in.engine_fan_on   = fan_in[0];
      out_in.dyno_fan_on     = fan_in[1];
      out_in.resistor_fan_on = fan_in[2];
      out_in.error_flags     = tick_active ? err_now : 5'd0;
      out_in.warning_flags   = tick_active ? warn_now : 2'd0;
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mode_ff  <= MODE_COLD;
         brake_ff <= 1'b0;
         pend_ff  <= 1'b0;
         ticks_ff <= '0;
         fan_ff   <= 3'd0;
      end else begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         brake_ff <= brake_in;
         pend_ff  <= pend_in;
         ticks_ff <= ticks_in;
         fan_ff   <= fan_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ebis_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // Kind and mode codes that the package leaves unnamed
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   // Fixed thresholds of the sequencer, tenths of a degree or percent
   localparam int FAN_MARGIN_ENGINE  = 100;
   localparam int FAN_ON_DYNO        = 800;
   localparam int FAN_ON_RESISTOR    = 1000;
   localparam int OIL_LVL_LOW        = 100;
   localparam int FUEL_LVL_LOW       = 50;
   localparam int WARMUP_FALLBACK    = 250;

   // Error and warning bit positions
   localparam int ERR_ENG_TEMP    = 0;
   localparam int ERR_OIL_PRESS   = 1;
   localparam int ERR_RPM         = 2;
   localparam int ERR_DYNO_TEMP   = 3;
   localparam int ERR_RES_TEMP    = 4;
   localparam int WARN_OIL        = 0;
   localparam int WARN_FUEL       = 1;

   typedef struct {
      logic [2:0]   kind;
      req_item_type body;
   } request_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic [REQ_TUSER_WIDTH-1:0] req_tuser  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   // Sequencer state as predicted
   phase_type   phase_now   = PH_IDLE;
   logic [1:0]  mode_now    = MODE_COLD;
   logic        brake_now   = 1'b0;
   logic        next_queued = 1'b0;
   logic [63:0] ticks_now   = '0;
   logic [2:0]  fans_now    = '0;

   // Limit and duration registers as predicted
   logic signed [12:0] lim_eng_temp    = 13'sd1100;
   logic [15:0]        lim_oil_min     = 16'd100;
   logic [15:0]        lim_oil_max     = 16'd6000;
   logic [13:0]        lim_rpm         = 14'd4000;
   logic signed [12:0] lim_dyno_temp   = 13'sd1200;
   logic signed [12:0] lim_res_temp    = 13'sd2000;
   logic [31:0]        run_ticks       = 32'd3000;
   logic [31:0]        warmup_ticks    = 32'd250;

   request_entry_type pending_requests[$];
   rsp_item_type expected_status[$];

   int send_idle_pct  = 19;
   int recv_idle_pct  = 65;
   int queued_total   = 0;
   int accepted_total = 0;
   int results_seen   = 0;
   int error_results  = 0;
   int fail_count     = 0;
   int settings_used  = 1;
   int cycle_count    = 0;
   int phase_seen[8];

   engine_breakin_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Compute the status that one request transaction produces
   function automatic rsp_item_type sequencer_step(logic [2:0] kind, req_item_type it);
      rsp_item_type st;
      logic [4:0]   err;
      logic [1:0]   warn;
      logic [31:0]  warm;
      logic [63:0]  tick_max;
      logic [1:0]   m;
      int           et;
      int           dt;
      int           rt;
      err = '0;
      warn = '0;
      et = int'(it.eng_temp);
      dt = int'(it.dyno_temp);
      rt = int'(it.res_temp);
      m = (it.mode == MODE_SPARE) ? MODE_HOT_LOAD : it.mode;
      tick_max = (64'd1 << TICK_COUNT_WIDTH) - 64'd1;
      case (kind)
         KIND_TICK: begin
            if (phase_now >= PH_COLD && phase_now <= PH_HOT_LOAD) begin
               // carry out a queued next-stage request first
               if (next_queued) begin
                  next_queued = 1'b0;
                  if (phase_now == PH_WARMUP) begin
                     phase_now = (mode_now == MODE_HOT_NL) ? PH_HOT_NL : PH_HOT_LOAD;
                     ticks_now = '0;
                  end else begin
                     phase_now = PH_STOPPED;
                  end
               end
               fans_now[0] = et > int'(lim_eng_temp) - FAN_MARGIN_ENGINE;
               fans_now[1] = dt > FAN_ON_DYNO;
               fans_now[2] = rt > FAN_ON_RESISTOR;
               // count the tick and check the timed phase change
               if (phase_now >= PH_COLD && phase_now <= PH_HOT_LOAD) begin
                  if (ticks_now < tick_max) ticks_now++;
                  warm = (warmup_ticks == 0) ? WARMUP_FALLBACK : warmup_ticks;
                  if (phase_now == PH_WARMUP) begin
                     if (ticks_now >= {32'd0, warm}) begin
                        phase_now = (mode_now == MODE_HOT_NL) ? PH_HOT_NL : PH_HOT_LOAD;
                        ticks_now = '0;
                     end
                  end else if (ticks_now >= {32'd0, run_ticks}) begin
                     phase_now = PH_STOPPED;
                  end
               end
               err[ERR_ENG_TEMP]  = et > int'(lim_eng_temp);
               err[ERR_OIL_PRESS] = it.oil_press < lim_oil_min ||
                                    it.oil_press > lim_oil_max;
               err[ERR_RPM]       = it.eng_speed > lim_rpm;
               err[ERR_DYNO_TEMP] = dt > int'(lim_dyno_temp);
               err[ERR_RES_TEMP]  = rt > int'(lim_res_temp);
               if (err != 5'd0) phase_now = PH_EMERG;
               warn[WARN_OIL]  = int'(it.oil_lvl) < OIL_LVL_LOW;
               warn[WARN_FUEL] = int'(it.fuel_lvl) < FUEL_LVL_LOW;
            end
         end
         KIND_START: begin
            mode_now = m;
            next_queued = 1'b0;
            ticks_now = '0;
            if (m == MODE_COLD) begin
               phase_now = PH_COLD;
               brake_now = 1'b0;
            end else begin
               phase_now = PH_WARMUP;
               brake_now = (m == MODE_HOT_LOAD);
            end
         end
         KIND_STOP: phase_now = PH_IDLE;
         KIND_ESTOP: phase_now = PH_EMERG;
         KIND_NEXT: next_queued = 1'b1;
         KIND_RESET_EMG: begin
            if (phase_now == PH_EMERG) begin
               phase_now = PH_IDLE;
               next_queued = 1'b0;
            end
         end
         KIND_SET_MODE: mode_now = m;
         default: ;
      endcase
      st.phase           = phase_now;
      st.current_mode    = mode_now;
      st.dyno_brake      = brake_now;
      st.eng_running     = (phase_now == PH_WARMUP || phase_now == PH_HOT_NL ||
                            phase_now == PH_HOT_LOAD);
      st.engine_fan_on   = fans_now[0];
      st.dyno_fan_on     = fans_now[1];
      st.resistor_fan_on = fans_now[2];
      st.error_flags     = err;
      st.warning_flags   = warn;
      return st;
   endfunction

   // Mirror one register write into the predicted limits
   function automatic void apply_csr(logic [2:0] index, logic [31:0] value);
      case (index)
         CSR_MAX_ENG_TEMP:  lim_eng_temp    = value[12:0];
         CSR_MIN_OIL_PRESS: lim_oil_min     = value[15:0];
         CSR_MAX_OIL_PRESS: lim_oil_max     = value[15:0];
         CSR_MAX_ENG_SPEED: lim_rpm         = value[13:0];
         CSR_MAX_DYNO_TEMP: lim_dyno_temp   = value[12:0];
         CSR_MAX_RES_TEMP:  lim_res_temp    = value[12:0];
         CSR_PHASE_TICKS:   run_ticks       = value;
         CSR_WARMUP_TICKS:  warmup_ticks    = value;
         default: ;
      endcase
   endfunction

   task automatic note_fail(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   task automatic cmp_field(string name, int want, int got);
      if (want != got)
         note_fail($sformatf("Mismatch on result %0d, %s: expected %0d, actual %0d",
                             results_seen, name, want, got));
   endtask

   // Compare one result transaction with the oldest predicted status
   task automatic check_status(rsp_item_type got);
      rsp_item_type want;
      results_seen++;
      phase_seen[got.phase]++;
      if (expected_status.size() == 0) begin
         note_fail($sformatf("Result %0d arrived with nothing outstanding: 0x%05h",
                             results_seen, got));
         return;
      end
      want = expected_status.pop_front();
      if (want.error_flags != 5'd0) error_results++;
      cmp_field("phase", int'(want.phase), int'(got.phase));
      cmp_field("current_mode", int'(want.current_mode), int'(got.current_mode));
      cmp_field("dyno_brake", int'(want.dyno_brake), int'(got.dyno_brake));
      cmp_field("eng_running", int'(want.eng_running), int'(got.eng_running));
      cmp_field("engine_fan_on", int'(want.engine_fan_on), int'(got.engine_fan_on));
      cmp_field("dyno_fan_on", int'(want.dyno_fan_on), int'(got.dyno_fan_on));
      cmp_field("resistor_fan_on", int'(want.resistor_fan_on),
                int'(got.resistor_fan_on));
      cmp_field("error_flags", int'(want.error_flags), int'(got.error_flags));
      cmp_field("warning_flags", int'(want.warning_flags), int'(got.warning_flags));
   endtask

   // Request driver: hold a transaction until accepted, idle at random
   always @(posedge clock) begin
      logic took;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         took = req_tvalid && req_tready;
         if (took) begin
            expected_status.push_back(
               sequencer_step(req_tuser, req_item_type'(req_tdata[REQ_ITEM_WIDTH-1:0])));
            void'(pending_requests.pop_front());
            accepted_total++;
         end
         if (req_tvalid && !took) begin
            // hold the transaction on the bus
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_TDATA_WIDTH-REQ_ITEM_WIDTH){1'b0}},
                           pending_requests[0].body};
            req_tuser  <= pending_requests[0].kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_status(rsp_item_type'(rsp_tdata[RSP_ITEM_WIDTH-1:0]));
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_item(logic [2:0] kind, req_item_type body);
      request_entry_type e;
      e.kind = kind;
      e.body = body;
      pending_requests.push_back(e);
      queued_total++;
   endtask

   function automatic req_item_type sensor(int et, int op, int rpm, int dt, int rt,
                                           int oil, int fuel);
      req_item_type s;
      s.mode      = MODE_COLD;
      s.eng_temp  = 13'(et);
      s.oil_press = 16'(op);
      s.eng_speed = 14'(rpm);
      s.dyno_temp = 13'(dt);
      s.res_temp  = 13'(rt);
      s.oil_lvl   = 10'(oil);
      s.fuel_lvl  = 10'(fuel);
      return s;
   endfunction

   task automatic queue_cmd(logic [2:0] kind, logic [1:0] mode);
      req_item_type s;
      s = sensor(500, 3000, 2000, 300, 300, 500, 500);
      s.mode = mode;
      queue_item(kind, s);
   endtask

   // Temperature at or below a limit, often close to it
   function automatic logic [12:0] temp_below(logic signed [12:0] lim);
      int lo;
      int hi;
      int v;
      hi = int'(lim);
      lo = $urandom_range(0, 1) ? hi - 400 : -500;
      if (lo > hi) lo = hi;
      if (lo < -4096) lo = -4096;
      v = lo + int'($urandom_range(0, hi - lo));
      return v[12:0];
   endfunction

   // Sensor reading inside every configured limit where the limits allow it
   function automatic req_item_type clean_reading();
      req_item_type s;
      s.mode      = 2'($urandom_range(0, 3));
      s.eng_temp  = temp_below(lim_eng_temp);
      s.dyno_temp = temp_below(lim_dyno_temp);
      s.res_temp  = temp_below(lim_res_temp);
      s.oil_press = (lim_oil_min <= lim_oil_max) ?
                    16'($urandom_range(lim_oil_min, lim_oil_max)) : 16'($urandom);
      s.eng_speed = 14'($urandom_range(0, lim_rpm));
      s.oil_lvl   = 10'($urandom_range(0, 1023));
      s.fuel_lvl  = 10'($urandom_range(0, 1023));
      return s;
   endfunction

   // Clean reading with one field replaced by raw random bits
   function automatic req_item_type skewed_reading();
      req_item_type s;
      s = clean_reading();
      case ($urandom_range(0, 6))
         0: s.eng_temp  = 13'($urandom);
         1: s.oil_press = 16'($urandom);
         2: s.eng_speed = 14'($urandom);
         3: s.dyno_temp = 13'($urandom);
         4: s.res_temp  = 13'($urandom);
         5: s.oil_lvl   = 10'($urandom);
         default: s.fuel_lvl = 10'($urandom);
      endcase
      return s;
   endfunction

   // One break-in run: start, ticks with a few commands, then a closing command or none
   task automatic queue_run(int max_run, int cmd_pct);
      int len;
      int r;
      logic [2:0] k;
      queue_cmd(KIND_START, 2'($urandom_range(0, 3)));
      len = $urandom_range(1, max_run);
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (r < cmd_pct) begin
            k = 3'($urandom_range(1, 7));
            queue_item(k, clean_reading());
         end else if (r < cmd_pct + 5) begin
            queue_item(KIND_TICK, skewed_reading());
         end else begin
            queue_item(KIND_TICK, clean_reading());
         end
      end
      case ($urandom_range(0, 3))
         0: queue_cmd(KIND_STOP, MODE_COLD);
         1: queue_cmd(KIND_RESET_EMG, MODE_COLD);
         2: queue_cmd(KIND_NEXT, MODE_COLD);
         default: ;
      endcase
   endtask

   task automatic queue_random(int count, int max_run, int cmd_pct);
      int start;
      logic [95:0] raw;
      start = queued_total;
      while (queued_total - start < count) begin
         if ($urandom_range(0, 99) < 12) begin
            raw = {$urandom, $urandom, $urandom};
            queue_item(3'($urandom_range(0, 7)), raw[REQ_ITEM_WIDTH-1:0]);
         end else begin
            queue_run(max_run, cmd_pct);
         end
      end
   endtask

   // Pause until every queued request has been answered
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || expected_status.size() != 0 || req_tvalid);
   endtask

   task automatic write_csr(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      apply_csr(index, value);
   endtask

   task automatic load_limits(int et, int op_min, int op_max, int rpm, int dt, int rt,
                              logic [31:0] run_len, logic [31:0] warm_len);
      write_csr(CSR_MAX_ENG_TEMP, et);
      write_csr(CSR_MIN_OIL_PRESS, op_min);
      write_csr(CSR_MAX_OIL_PRESS, op_max);
      write_csr(CSR_MAX_ENG_SPEED, rpm);
      write_csr(CSR_MAX_DYNO_TEMP, dt);
      write_csr(CSR_MAX_RES_TEMP, rt);
      write_csr(CSR_PHASE_TICKS, run_len);
      write_csr(CSR_WARMUP_TICKS, warm_len);
      settings_used++;
      @(negedge clock);
   endtask

   // Random phase under one limit setting, with a full drain halfway
   task automatic run_phase(int s_idle, int r_idle, int et, int op_min, int op_max,
                            int rpm, int dt, int rt, logic [31:0] run_len,
                            logic [31:0] warm_len, int count, int max_run, int cmd_pct);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      load_limits(et, op_min, op_max, rpm, dt, rt, run_len, warm_len);
      queue_random(count / 2, max_run, cmd_pct);
      wait_drained();
      queue_random(count - count / 2, max_run, cmd_pct);
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset limits, boundaries, limit errors, emergency handling
      queue_item(KIND_TICK, sensor(500, 3000, 2000, 300, 300, 500, 500));
      queue_cmd(KIND_NEXT, MODE_COLD);
      queue_cmd(KIND_START, MODE_COLD);
      queue_item(KIND_TICK, sensor(1100, 100, 4000, 1200, 2000, 99, 49));
      queue_item(KIND_TICK, sensor(1000, 6000, 0, 800, 1000, 100, 50));
      queue_item(KIND_TICK, sensor(1101, 6001, 4001, 1201, 2001, 500, 500));
      queue_cmd(KIND_RESET_EMG, MODE_COLD);
      queue_cmd(KIND_RESET_EMG, MODE_COLD);
      wait_drained();

      // Directed: short durations, saturated mode, timed and requested changes
      load_limits(1100, 100, 6000, 4000, 1200, 2000, 3, 2);
      queue_cmd(KIND_START, MODE_SPARE);
      queue_cmd(KIND_SET_MODE, MODE_HOT_NL);
      queue_item(KIND_TICK, sensor(500, 3000, 2000, 300, 300, 500, 500));
      queue_item(KIND_TICK, sensor(500, 3000, 2000, 300, 300, 500, 500));
      queue_cmd(KIND_NEXT, MODE_COLD);
      queue_item(KIND_TICK, sensor(500, 3000, 2000, 300, 300, 500, 500));
      queue_cmd(KIND_START, MODE_COLD);
      queue_item(KIND_TICK, sensor(500, 3000, 2000, 300, 300, 500, 500));
      queue_item(KIND_TICK, sensor(500, 3000, 2000, 300, 300, 500, 500));
      // limit error on the tick that ends the run, all fields at their minimum
      queue_item(KIND_TICK, sensor(-4096, 0, 0, -4096, -4096, 0, 0));
      queue_cmd(KIND_UNUSED, MODE_SPARE);
      queue_cmd(KIND_RESET_EMG, MODE_COLD);
      queue_cmd(KIND_START, MODE_HOT_LOAD);
      queue_item(KIND_TICK, sensor(4095, 65535, 16383, 4095, 4095, 1023, 1023));
      queue_cmd(KIND_STOP, MODE_COLD);
      queue_cmd(KIND_ESTOP, MODE_COLD);
      wait_drained();

      // Random phases, idle pattern changes every two settings
      run_phase(19, 65, 1100, 100, 6000, 4000, 1200, 2000, 25, 6, 170, 40, 8);
      run_phase(19, 65, 3000, 0, 65535, 16383, 3000, 3000, 0, 1, 170, 30, 8);
      run_phase(65, 19, -500, 3000, 3100, 2000, -500, -500, 32'hFFFF_FFFF, 3,
                170, 40, 8);
      run_phase(65, 19, 1100, 100, 6000, 4000, 1200, 2000, 40, 0, 200, 300, 1);
      run_phase(0, 0, 0, 65535, 65535, 0, 3000, -500, 1, 32'hFFFF_FFFF, 170, 40, 8);
      run_phase(0, 0, 2000, 500, 50000, 8000, 2500, 2800, 12, 5, 170, 40, 8);

      repeat (10) @(negedge clock);
      if (expected_status.size() != 0) begin
         note_fail($sformatf("%0d expected results never arrived", expected_status.size()));
      end
      $write("Sent %0d requests under %0d limit settings; ", accepted_total, settings_used);
      $display("checked %0d results, %0d with limit errors.", results_seen, error_results);
      $write("Reported phases: idle %0d, cold %0d, warmup %0d, ",
             phase_seen[0], phase_seen[1], phase_seen[2]);
      $display("hot no load %0d, hot load %0d, stopped %0d, emergency %0d",
               phase_seen[3], phase_seen[4], phase_seen[5], phase_seen[6]);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/ebis_pkg.sv
rtl/core/engine_breakin_sequencer_top.sv
test/testbench.sv
